// ===== rtl/overwriting_ring_buffer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the overwriting ring buffer
// Implication checks, clocked on the rising edge and idle during reset.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_RING_BUFFER_CORE_ASSERT_SVH
`define OVERWRITING_RING_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication
`define ORB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("orb assertion failed");

// Next-cycle implication
`define ORB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("orb assertion failed");

`endif

// ===== rtl/orb_pkg.sv =====
// ----------------------------------------------------------------------------
// orb_pkg
// Sizes, codes, command type and helpers shared by the ring buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

  localparam int DEPTH     = 64;
  localparam int MAX_LANES = 4;
  localparam int MAX_RUN   = 16;

  localparam int LANE_W    = 16;
  localparam int OUT_LANES = 4;
  localparam int ENTRY_W   = MAX_LANES * LANE_W;
  localparam int PAD_W     = OUT_LANES * LANE_W;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int FILL_W    = $clog2(DEPTH + 1);
  localparam int CNT_W     = $clog2(MAX_RUN + 1);
  localparam int SUM_W     = ((FILL_W > CNT_W) ? FILL_W : CNT_W) + 1;
  localparam int OPC_W     = 3;
  localparam int RUNCNT_W  = 5;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int LANES_W   = 3;

  localparam int CQ_DEPTH  = 2;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);

  typedef enum logic [OPC_W-1:0] {
    OP_PUT    = 3'd0,
    OP_GET    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_GET_N  = 3'd3,
    OP_PEEK_N = 3'd4,
    OP_RESET  = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NONE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_RUN,
    CMD_CLEAR
  } cmd_kind_e;

  typedef enum logic {
    BS_IDLE,
    BS_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               pop;
    logic [CNT_W-1:0]   count;
    logic [ENTRY_W-1:0] data;
  } cmd_t;

  // Zero the lanes at or above the effective lane count (0 acts as 1).
  function automatic logic [ENTRY_W-1:0] mask_lanes(input logic [ENTRY_W-1:0] data,
                                                     input logic [LANES_W-1:0] lanes);
    logic [ENTRY_W-1:0] res;
    int                 n;
    n = int'(lanes);
    if (n < 1) n = 1;
    if (n > MAX_LANES) n = MAX_LANES;
    for (int i = 0; i < MAX_LANES; i++) begin
      res[i*LANE_W +: LANE_W] = (i < n) ? data[i*LANE_W +: LANE_W] : '0;
    end
    return res;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/orb_in_if.sv =====
// ----------------------------------------------------------------------------
// orb_in_if
// Request channel: one operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface orb_in_if import orb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPC_W-1:0]        opcode;
  logic [RUNCNT_W-1:0]     run_count;
  logic signed [LANE_W-1:0] in_lane_0;
  logic signed [LANE_W-1:0] in_lane_1;
  logic signed [LANE_W-1:0] in_lane_2;
  logic signed [LANE_W-1:0] in_lane_3;

  modport source (output valid, opcode, run_count, in_lane_0, in_lane_1, in_lane_2,
                  in_lane_3, input ready);
  modport sink   (input valid, opcode, run_count, in_lane_0, in_lane_1, in_lane_2,
                  in_lane_3, output ready);
endinterface

`default_nettype wire

// ===== rtl/orb_out_if.sv =====
// ----------------------------------------------------------------------------
// orb_out_if
// Result channel: one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface orb_out_if import orb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     overwrote_oldest;
  logic signed [LANE_W-1:0] out_lane_0;
  logic signed [LANE_W-1:0] out_lane_1;
  logic signed [LANE_W-1:0] out_lane_2;
  logic signed [LANE_W-1:0] out_lane_3;
  logic [POS_W-1:0]         run_position;
  logic                     last_of_run;

  modport source (output valid, status, overwrote_oldest, out_lane_0, out_lane_1,
                  out_lane_2, out_lane_3, run_position, last_of_run, input ready);
  modport sink   (input valid, status, overwrote_oldest, out_lane_0, out_lane_1,
                  out_lane_2, out_lane_3, run_position, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/orb_ram.sv =====
// ----------------------------------------------------------------------------
// orb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/orb_front.sv =====
// ----------------------------------------------------------------------------
// orb_front
// Decodes request transactions into buffer commands for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_front import orb_pkg::*; (
  orb_in_if.sink               item_i,
  input  wire logic [LANES_W-1:0] lanes_i,
  input  wire logic            push_ready_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic             cmd_known;
  logic [CNT_W-1:0] count_sat;

  assign item_i.ready = push_ready_i;

  // saturate the requested run length
  assign count_sat = (int'(item_i.run_count) > MAX_RUN) ? CNT_W'(MAX_RUN)
                                                        : CNT_W'(item_i.run_count);

  always_comb begin
    cmd_known   = 1'b1;
    cmd_o.kind  = CMD_PUT;
    cmd_o.pop   = 1'b0;
    cmd_o.count = CNT_W'(1);
    cmd_o.data  = mask_lanes(ENTRY_W'({item_i.in_lane_3, item_i.in_lane_2,
                                       item_i.in_lane_1, item_i.in_lane_0}), lanes_i);
    case (opcode_e'(item_i.opcode))
      OP_PUT: begin
        cmd_o.kind = CMD_PUT;
      end
      OP_GET: begin
        cmd_o.kind = CMD_RUN;
        cmd_o.pop  = 1'b1;
      end
      OP_PEEK: begin
        cmd_o.kind = CMD_RUN;
      end
      OP_GET_N: begin
        cmd_o.kind  = CMD_RUN;
        cmd_o.pop   = 1'b1;
        cmd_o.count = count_sat;
      end
      OP_PEEK_N: begin
        cmd_o.kind  = CMD_RUN;
        cmd_o.count = count_sat;
      end
      OP_RESET: begin
        cmd_o.kind = CMD_CLEAR;
      end
      default: begin
        // drop unknown opcodes
        cmd_known = 1'b0;
      end
    endcase
  end

  assign push_o = item_i.valid && push_ready_i && cmd_known;

endmodule

`default_nettype wire

// ===== rtl/orb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// orb_cmd_queue
// Short command queue between the decode front and the execute back end.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_cmd_queue import orb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      not_full_o,
  input  wire logic pop_i,
  output logic      not_empty_o,
  output cmd_t      cmd_o
);

  cmd_t                slot_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_PTR_W:0]   used_q, used_d;

  function automatic logic [CQ_PTR_W-1:0] qadv(input logic [CQ_PTR_W-1:0] p);
    return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign not_full_o  = (used_q != (CQ_PTR_W + 1)'(CQ_DEPTH));
  assign not_empty_o = (used_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? qadv(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? qadv(rd_ptr_q) : rd_ptr_q;
    used_d   = used_q + (CQ_PTR_W + 1)'(push_i) - (CQ_PTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/orb_back.sv =====
// ----------------------------------------------------------------------------
// orb_back
// Executes buffer commands against the entry RAM and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "overwriting_ring_buffer_core_assert.svh"

module orb_back import orb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  cmd_t                    cmd_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_pop_o,
  input  wire logic [LANES_W-1:0] lanes_i,
  orb_out_if.source               result_o
);

  back_state_e      state_q, state_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic             empty_q, empty_d;
  logic [PTR_W-1:0] rdp_q, rdp_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic               out_over_q;
  logic [ENTRY_W-1:0] out_data_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_last_q;
  logic [PAD_W-1:0]   out_pad;

  logic               load;
  status_e            ld_status;
  logic               ld_over;
  logic [ENTRY_W-1:0] ld_data;
  logic [POS_W-1:0]   ld_pos;
  logic               ld_last;

  logic               out_free;
  logic [FILL_W-1:0]  fill;
  logic [CNT_W-1:0]   take;
  logic [SUM_W-1:0]   rp_sum;
  logic [PTR_W-1:0]   rp_after;

  logic               ram_we;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  orb_ram #(
    .Width (ENTRY_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || result_o.ready;

  // entries held; full when not empty and the pointers meet
  always_comb begin
    if (empty_q) begin
      fill = '0;
    end else if (wp_q == rp_q) begin
      fill = FILL_W'(DEPTH);
    end else if (wp_q > rp_q) begin
      fill = FILL_W'(wp_q - rp_q);
    end else begin
      fill = FILL_W'(DEPTH) - FILL_W'(rp_q) + FILL_W'(wp_q);
    end
  end

  assign take     = (SUM_W'(cmd_i.count) < SUM_W'(fill)) ? cmd_i.count : CNT_W'(fill);
  assign rp_sum   = SUM_W'(rp_q) + SUM_W'(take);
  assign rp_after = (rp_sum >= SUM_W'(DEPTH)) ? PTR_W'(rp_sum - SUM_W'(DEPTH))
                                              : PTR_W'(rp_sum);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    empty_d   = empty_q;
    rdp_d     = rdp_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rp_q;
    load      = 1'b0;
    ld_status = ST_OK;
    ld_over   = 1'b0;
    ld_data   = '0;
    ld_pos    = '0;
    ld_last   = 1'b1;
    case (state_q)
      BS_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_PUT: begin
              ram_we  = 1'b1;
              load    = 1'b1;
              ld_over = !empty_q && (rp_q == wp_q);
              // drop the oldest entry on a full buffer
              if (ld_over) begin
                rp_d = ptr_adv(rp_q);
              end
              empty_d = 1'b0;
              wp_d    = ptr_adv(wp_q);
            end
            CMD_RUN: begin
              if (empty_q) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else if (cmd_i.count == '0) begin
                load      = 1'b1;
                ld_status = ST_NONE;
              end else begin
                ram_re  = 1'b1;
                rdp_d   = ptr_adv(rp_q);
                rem_d   = take;
                pos_d   = '0;
                state_d = BS_EMIT;
                if (cmd_i.pop) begin
                  rp_d    = rp_after;
                  empty_d = (rp_after == wp_q);
                end
              end
            end
            CMD_CLEAR: begin
              load    = 1'b1;
              wp_d    = '0;
              rp_d    = '0;
              empty_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BS_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = mask_lanes(ram_rdata, lanes_i);
          ld_pos  = pos_q;
          ld_last = (rem_q == CNT_W'(1));
          rem_d   = rem_q - 1'b1;
          pos_d   = pos_q + 1'b1;
          // fetch the next entry of the run while this one goes out
          if (rem_q != CNT_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = rdp_q;
            rdp_d     = ptr_adv(rdp_q);
          end else begin
            state_d = BS_IDLE;
          end
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      empty_q     <= 1'b1;
      rdp_q       <= '0;
      rem_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      empty_q     <= empty_d;
      rdp_q       <= rdp_d;
      rem_q       <= rem_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= ld_status;
      out_over_q   <= ld_over;
      out_data_q   <= ld_data;
      out_pos_q    <= ld_pos;
      out_last_q   <= ld_last;
    end
  end

  assign out_pad                   = PAD_W'(out_data_q);
  assign result_o.valid            = out_valid_q;
  assign result_o.status           = out_status_q;
  assign result_o.overwrote_oldest = out_over_q;
  assign result_o.out_lane_0       = out_pad[0*LANE_W +: LANE_W];
  assign result_o.out_lane_1       = out_pad[1*LANE_W +: LANE_W];
  assign result_o.out_lane_2       = out_pad[2*LANE_W +: LANE_W];
  assign result_o.out_lane_3       = out_pad[3*LANE_W +: LANE_W];
  assign result_o.run_position     = out_pos_q;
  assign result_o.last_of_run      = out_last_q;

  `ORB_ASSERT_IMPL(a_no_write_in_run, clk_i, rst_ni, state_q == BS_EMIT, !ram_we)
  `ORB_ASSERT_IMPL(a_run_not_spent, clk_i, rst_ni, state_q == BS_EMIT, rem_q != '0)
  `ORB_ASSERT_IMPL(a_empty_ptrs_meet, clk_i, rst_ni, empty_q, rp_q == wp_q)
  `ORB_ASSERT_IMPL(a_pop_has_cmd, clk_i, rst_ni, cmd_pop_o, cmd_valid_i)
  `ORB_ASSERT_NEXT(a_last_ends_run, clk_i, rst_ni,
                   state_q == BS_EMIT && out_free && rem_q == CNT_W'(1), state_q == BS_IDLE)

endmodule

`default_nettype wire

// ===== rtl/overwriting_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_core
// Overwriting ring buffer of multi-lane entries with single and run reads.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries one operation per transaction (put, get, peek, get_n,
//   peek_n, reset); result_o returns one result per transaction, and a run
//   returns one result per entry with last_of_run on the final one. Unknown
//   opcodes are dropped without a result. cfg_we_i/cfg_wdata_i set the lane
//   count; write it only while no operation is in flight.
//   A result passes through the command queue and the result register; the
//   first entry of a read also passes through the registered read port of
//   the entry RAM.
//   The execute stage works on a single command: put, reset and empty or
//   zero-count reads complete from idle, and a read of k entries first reads
//   the one RAM read port and then emits its entries before the next command.
//   A two-deep command queue lets requests be taken while results stall.
//   When result_o.ready is low with a result held, the result register
//   holds and execution stops; item_i.ready drops once the queue fills.
//   Reset empties the buffer, sets the lane count to one and leaves the
//   entry RAM as it was.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_buffer_core import orb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  orb_in_if.sink                  item_i,
  orb_out_if.source               result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [LANES_W-1:0] cfg_wdata_i
);

  logic [LANES_W-1:0] lanes_q, lanes_d;
  cmd_t               front_cmd;
  logic               front_push;
  logic               queue_not_full;
  cmd_t               queue_cmd;
  logic               queue_not_empty;
  logic               back_pop;

  assign lanes_d = cfg_we_i ? cfg_wdata_i : lanes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= LANES_W'(1);
    end else begin
      lanes_q <= lanes_d;
    end
  end

  orb_front u_front (
    .item_i       (item_i),
    .lanes_i      (lanes_q),
    .push_ready_i (queue_not_full),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  orb_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_push),
    .cmd_i       (front_cmd),
    .not_full_o  (queue_not_full),
    .pop_i       (back_pop),
    .not_empty_o (queue_not_empty),
    .cmd_o       (queue_cmd)
  );

  orb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_not_empty),
    .cmd_pop_o   (back_pop),
    .lanes_i     (lanes_q),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
